// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

   typedef enum logic [3:0] {
      OP_FROM_FLOAT = 4'd0,
      OP_FROM_INT   = 4'd1,
      OP_TO_FLOAT   = 4'd2,
      OP_TO_INT     = 4'd3,
      OP_ADD        = 4'd4,
      OP_SUB        = 4'd5,
      OP_MUL        = 4'd6,
      OP_DIV        = 4'd7,
      OP_COMPARE    = 4'd8,
      OP_INC        = 4'd9,
      OP_DEC        = 4'd10,
      OP_MIN        = 4'd11,
      OP_MAX        = 4'd12
   } op_type;

   localparam int ExpBias  = 127;
   localparam int MantBits = 23;
   localparam int ExpBits  = 8;
   localparam logic [31:0] SignBit = 32'h8000_0000;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] op_a;
      logic [31:0] op_b;
      logic [31:0] float_in;
      logic [23:0] int_in;
   } entry_type;

   typedef struct packed {
      logic [31:0] raw_result;
      logic [31:0] float_out;
      logic [23:0] int_out;
      logic        less_than;
      logic        equal_to;
      logic        greater_than;
      logic        range_error;
   } result_type;

   function automatic logic [4:0] lead_one(input logic [31:0] v);
      logic [4:0] idx;
      idx = 5'd0;
      for (int i = 1; i < 32; i++) begin
         if (v[i]) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/fpa_front.sv =====
module fpa_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [3:0]          req_type,
   input  logic signed [31:0]  req_op_a,
   input  logic signed [31:0]  req_op_b,
   input  logic [31:0]         req_float_in,
   input  logic signed [23:0]  req_int_in,
   output logic                q_valid,
   output fpa_pkg::entry_type  q_entry,
   input  logic                q_pop
);
   logic               full_ff, full_in;
   fpa_pkg::entry_type entry_ff, entry_in;

   assign busy    = full_ff;
   assign q_valid = full_ff;
   assign q_entry = entry_ff;

   always_comb begin
      full_in  = full_ff;
      entry_in = entry_ff;
      if (q_pop) begin
         full_in = 1'b0;
      end
      if (start && !full_ff) begin
         full_in           = 1'b1;
         entry_in.op       = req_type;
         entry_in.op_a     = req_op_a;
         entry_in.op_b     = req_op_b;
         entry_in.float_in = req_float_in;
         entry_in.int_in   = req_int_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end
endmodule

// ===== rtl/fpa_back.sv =====
module fpa_back #(
   parameter int FRAC_WIDTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  fpa_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               res_valid,
   output fpa_pkg::result_type res
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_MUL  = 3'b100
   } state_type;

   localparam int DivSteps = 32 + FRAC_WIDTH;
   localparam int CntW = $clog2(DivSteps + 1);

   state_type           state_ff, state_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [63:0]         num_ff, num_in;
   logic [32:0]         rem_ff, rem_in;
   logic [31:0]         den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [63:0]         prod_ff, prod_in;
   logic                rv_ff, rv_in;
   fpa_pkg::result_type res_ff, res_in;

   fpa_pkg::result_type quick;
   logic signed [31:0]  a, b;
   logic [31:0]         mag, mb, tr, fr;
   logic [4:0]          lo;
   logic [32:0]         tt, trial;
   logic signed [33:0]  iv;
   logic [31:0]         fmag, fmant;
   logic signed [9:0]   fexp, fs;
   logic [63:0]         fshift;

   assign a = q_entry.op_a;
   assign b = q_entry.op_b;
   assign res_valid = rv_ff;
   assign res = res_ff;

   always_comb begin
      quick = '0;
      mag   = a[31] ? 32'(-a) : a;
      mb    = b[31] ? 32'(-b) : b;
      lo    = fpa_pkg::lead_one(mag);
      fr    = '0;
      tr    = mag;
      tt    = '0;
      iv    = '0;
      fmant = {8'd0, 1'b1, q_entry.float_in[22:0]};
      fexp  = 10'(q_entry.float_in[30:23]) - 10'(fpa_pkg::ExpBias);
      fs    = fexp - 10'(fpa_pkg::MantBits) + 10'(FRAC_WIDTH);
      fshift = '0;
      fmag  = '0;
      case (q_entry.op)
         fpa_pkg::OP_FROM_FLOAT: begin
            if (fexp >= 10'(31 - FRAC_WIDTH)) begin
               if (q_entry.float_in[31] && fexp == 10'(31 - FRAC_WIDTH)
                   && q_entry.float_in[22:0] == '0) begin
                  quick.raw_result = 32'h8000_0000;
               end else begin
                  quick.range_error = 1'b1;
                  quick.raw_result = q_entry.float_in[31] ? 32'h8000_0000
                                                          : 32'h7FFF_FFFF;
               end
            end else begin
               if (fs >= 0) begin
                  fshift = {32'd0, fmant} << fs[5:0];
               end else if (-fs >= 10'sd32) begin
                  fshift = '0;
               end else begin
                  fshift = {32'd0, fmant >> 6'(-fs)};
               end
               fmag = fshift[31:0];
               quick.raw_result = q_entry.float_in[31] ? 32'(-fmag) : fmag;
            end
         end
         fpa_pkg::OP_FROM_INT:
            quick.raw_result = 32'({{8{q_entry.int_in[23]}}, q_entry.int_in} << FRAC_WIDTH);
         fpa_pkg::OP_TO_FLOAT: begin
            if (mag != '0) begin
               if (lo >= 5'(fpa_pkg::MantBits)) begin
                  fr = mag >> (lo - 5'(fpa_pkg::MantBits));
               end else begin
                  fr = mag << (5'(fpa_pkg::MantBits) - lo);
               end
               quick.float_out = {a[31], 8'(32'(lo) - FRAC_WIDTH + fpa_pkg::ExpBias),
                                  fr[22:0]};
            end
         end
         fpa_pkg::OP_TO_INT: begin
            if (lo > 5'(fpa_pkg::MantBits)) begin
               tr = mag & ~((32'd1 << (lo - 5'(fpa_pkg::MantBits))) - 32'd1);
            end
            tt = ({1'b0, tr} + (33'd1 << (FRAC_WIDTH - 1))) >> FRAC_WIDTH;
            iv = a[31] ? -$signed({1'b0, tt}) : $signed({1'b0, tt});
            if (iv > 34'sd8388607) begin
               quick.int_out = 24'h7F_FFFF;
            end else if (iv < -34'sd8388608) begin
               quick.int_out = 24'h80_0000;
            end else begin
               quick.int_out = iv[23:0];
            end
         end
         fpa_pkg::OP_ADD: quick.raw_result = 32'(a + b);
         fpa_pkg::OP_SUB: quick.raw_result = 32'(a - b);
         fpa_pkg::OP_COMPARE: begin
            quick.less_than    = a < b;
            quick.equal_to     = a == b;
            quick.greater_than = a > b;
         end
         fpa_pkg::OP_INC: quick.raw_result = 32'(a + 32'sd1);
         fpa_pkg::OP_DEC: quick.raw_result = 32'(a - 32'sd1);
         fpa_pkg::OP_MIN: quick.raw_result = (a < b) ? a : b;
         fpa_pkg::OP_MAX: quick.raw_result = (a > b) ? a : b;
         fpa_pkg::OP_DIV: quick.range_error = (b == '0);
         default: quick = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      rv_in    = 1'b0;
      res_in   = res_ff;
      q_pop    = 1'b0;
      trial    = {rem_ff[31:0], num_ff[63]} - {1'b0, den_ff};
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.op == fpa_pkg::OP_DIV && b != '0) begin
                  state_in = S_DIV;
                  num_in   = {mag, 32'd0};
                  den_in   = mb;
                  rem_in   = '0;
                  neg_in   = a[31] ^ b[31];
                  cnt_in   = CntW'(DivSteps);
               end else if (q_entry.op == fpa_pkg::OP_MUL) begin
                  state_in = S_MUL;
                  prod_in  = 64'($signed(a) * $signed(b));
               end else begin
                  rv_in  = 1'b1;
                  res_in = quick;
               end
            end
         end
         S_DIV: begin
            if (!trial[32]) begin
               rem_in = trial;
               num_in = {num_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], num_ff[63]};
               num_in = {num_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            res_in = '0;
            res_in.raw_result = 32'($signed(prod_ff) >>> FRAC_WIDTH);
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_DIV && cnt_ff == CntW'(1)) begin
         rv_in  = 1'b1;
         res_in = '0;
         res_in.raw_result = neg_ff ? 32'(-num_in[31:0]) : num_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end
endmodule

// ===== rtl/fixed_point_alu_with_float_convert_core.sv =====
// Fixed-point ALU with float conversion, signed 32-bit words, FRAC_WIDTH fraction bits.
// Request channel: drive req_* and raise start; a request is taken at a clock edge
// where start is high and busy is low. busy is high while the one-entry queue
// between the front and the execution unit holds a request.
// Response channel: rsp_valid is high for exactly one cycle with all rsp_* fields;
// fields an operation does not produce are zero. The receiver cannot stall.
// From acceptance: the queue holds the request until the execution unit pops it and
// registers the result; mul goes through a product register, div through the restoring
// divider, one quotient bit per cycle. The queue can refill while a div runs.
// Reset clears the queue and the execution state; no request is in flight after.
module fixed_point_alu_with_float_convert_core #(
   parameter int FRAC_WIDTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_type,
   input  logic signed [31:0] req_op_a,
   input  logic signed [31:0] req_op_b,
   input  logic [31:0]        req_float_in,
   input  logic signed [23:0] req_int_in,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_raw_result,
   output logic [31:0]        rsp_float_out,
   output logic signed [23:0] rsp_int_out,
   output logic               rsp_less_than,
   output logic               rsp_equal_to,
   output logic               rsp_greater_than,
   output logic               rsp_range_error
);
   logic                q_valid, q_pop;
   fpa_pkg::entry_type  q_entry;
   fpa_pkg::result_type res;

   fpa_front u_front (
      .clock, .reset, .start, .busy, .req_type, .req_op_a, .req_op_b,
      .req_float_in, .req_int_in, .q_valid, .q_entry, .q_pop
   );

   fpa_back #(.FRAC_WIDTH(FRAC_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_entry, .q_pop,
      .res_valid(rsp_valid), .res
   );

   assign rsp_raw_result   = res.raw_result;
   assign rsp_float_out    = res.float_out;
   assign rsp_int_out      = res.int_out;
   assign rsp_less_than    = res.less_than;
   assign rsp_equal_to     = res.equal_to;
   assign rsp_greater_than = res.greater_than;
   assign rsp_range_error  = res.range_error;
endmodule

// ===== rtl/fpa_checker.sv =====
module fpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_less_than,
   input logic        rsp_equal_to,
   input logic        rsp_greater_than
);
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_less_than || rsp_equal_to || rsp_greater_than)
      |-> $onehot({rsp_less_than, rsp_equal_to, rsp_greater_than}))
      else $error("compare flags not exclusive");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not set busy");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");
endmodule

bind fixed_point_alu_with_float_convert_core fpa_checker u_chk (
   .clock, .reset, .start, .busy, .rsp_valid,
   .rsp_less_than, .rsp_equal_to, .rsp_greater_than
);

// ===== tb/tb_top.sv =====
module tb_top;

   localparam int FracWidth = 8;

   class alu_scoreboard;
      fpa_pkg::result_type pending[$];
      int                  errors;

      function new();
         errors = 0;
      endfunction

      function automatic logic [31:0] abs_val(input logic signed [31:0] a);
         return a[31] ? 32'(-a) : a;
      endfunction

      function automatic int top_bit(input logic [31:0] v);
         int idx;
         idx = 0;
         for (int i = 1; i < 32; i++) begin
            if (v[i]) begin
               idx = i;
            end
         end
         return idx;
      endfunction

      function automatic logic [31:0] fixed_from_single(input logic [31:0] f,
                                                          output logic err);
         logic        neg;
         int          e;
         int          s;
         logic [63:0] m;
         logic [63:0] mag;
         neg = f[31];
         e = int'(f[30:23]) - fpa_pkg::ExpBias;
         m = {40'd0, 1'b1, f[22:0]};
         s = e - fpa_pkg::MantBits + FracWidth;
         err = 1'b0;
         if (e >= 31 - FracWidth) begin
            if (neg && e == 31 - FracWidth && f[22:0] == 0) begin
               return fpa_pkg::SignBit;
            end
            err = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
         end
         if (s >= 0) begin
            mag = m << s;
         end else if (-s >= 32) begin
            mag = 0;
         end else begin
            mag = m >> (-s);
         end
         return neg ? 32'(-mag) : mag[31:0];
      endfunction

      function automatic logic [31:0] single_from_fixed(input logic signed [31:0] a);
         logic [31:0] mag;
         logic [31:0] r;
         int          i;
         mag = abs_val(a);
         if (mag == 0) begin
            return 0;
         end
         i = top_bit(mag);
         if (i >= fpa_pkg::MantBits) begin
            r = (mag >> (i - fpa_pkg::MantBits)) & 32'h7f_ffff;
         end else begin
            r = (mag << (fpa_pkg::MantBits - i)) & 32'h7f_ffff;
         end
         if (a < 0) begin
            r |= fpa_pkg::SignBit;
         end
         r |= 32'(i - FracWidth + fpa_pkg::ExpBias) << fpa_pkg::MantBits;
         return r;
      endfunction

      function automatic logic [23:0] round_to_int(input logic signed [31:0] a);
         logic [63:0]        t;
         longint             v;
         int                 i;
         t = {32'd0, abs_val(a)};
         if (t == 0) begin
            return 0;
         end
         i = top_bit(t[31:0]);
         if (i > fpa_pkg::MantBits) begin
            t &= ~((64'd1 << (i - fpa_pkg::MantBits)) - 64'd1);
         end
         t = (t + (64'd1 << (FracWidth - 1))) >> FracWidth;
         v = a < 0 ? -longint'(t) : longint'(t);
         if (v > 8388607) begin
            v = 8388607;
         end
         if (v < -8388608) begin
            v = -8388608;
         end
         return v[23:0];
      endfunction

      function void note_request(input logic [3:0] op, input logic signed [31:0] a,
                                 input logic signed [31:0] b, input logic [31:0] f,
                                 input logic signed [23:0] n);
         fpa_pkg::result_type r;
         longint              p;
         longint              q;
         r = '0;
         case (op)
            fpa_pkg::OP_FROM_FLOAT: r.raw_result = fixed_from_single(f, r.range_error);
            fpa_pkg::OP_FROM_INT:   r.raw_result = 32'(longint'(n) <<< FracWidth);
            fpa_pkg::OP_TO_FLOAT:   r.float_out = single_from_fixed(a);
            fpa_pkg::OP_TO_INT:     r.int_out = round_to_int(a);
            fpa_pkg::OP_ADD:        r.raw_result = a + b;
            fpa_pkg::OP_SUB:        r.raw_result = a - b;
            fpa_pkg::OP_MUL: begin
               p = longint'(a) * longint'(b);
               r.raw_result = 32'(p >>> FracWidth);
            end
            fpa_pkg::OP_DIV: begin
               if (b == 0) begin
                  r.range_error = 1'b1;
               end else begin
                  q = (longint'(a) * (64'sd1 <<< FracWidth)) / longint'(b);
                  r.raw_result = q[31:0];
               end
            end
            fpa_pkg::OP_COMPARE: begin
               r.less_than = a < b;
               r.equal_to = a == b;
               r.greater_than = a > b;
            end
            fpa_pkg::OP_INC: r.raw_result = a + 32'sd1;
            fpa_pkg::OP_DEC: r.raw_result = a - 32'sd1;
            fpa_pkg::OP_MIN: r.raw_result = a < b ? a : b;
            fpa_pkg::OP_MAX: r.raw_result = a > b ? a : b;
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_result(input fpa_pkg::result_type got);
         fpa_pkg::result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.raw_result !== want.raw_result)
            $display("%0t: raw_result exp %h act %h", $realtime, want.raw_result,
                     got.raw_result);
         if (got.float_out !== want.float_out)
            $display("%0t: float_out exp %h act %h", $realtime, want.float_out,
                     got.float_out);
         if (got.int_out !== want.int_out)
            $display("%0t: int_out exp %h act %h", $realtime, want.int_out, got.int_out);
         if (got.less_than !== want.less_than || got.equal_to !== want.equal_to ||
             got.greater_than !== want.greater_than)
            $display("%0t: compare exp %b%b%b act %b%b%b", $realtime, want.less_than,
                     want.equal_to, want.greater_than, got.less_than, got.equal_to,
                     got.greater_than);
         if (got.range_error !== want.range_error)
            $display("%0t: range_error exp %b act %b", $realtime, want.range_error,
                     got.range_error);
         if (got !== want) begin
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [3:0]         req_type = '0;
   logic signed [31:0] req_op_a = '0;
   logic signed [31:0] req_op_b = '0;
   logic [31:0]        req_float_in = '0;
   logic signed [23:0] req_int_in = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_raw_result;
   logic [31:0]        rsp_float_out;
   logic signed [23:0] rsp_int_out;
   logic               rsp_less_than;
   logic               rsp_equal_to;
   logic               rsp_greater_than;
   logic               rsp_range_error;

   alu_scoreboard alu_sb = new();

   fixed_point_alu_with_float_convert_core #(.FRAC_WIDTH(FracWidth)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_op_a(req_op_a), .req_op_b(req_op_b),
      .req_float_in(req_float_in), .req_int_in(req_int_in),
      .rsp_valid(rsp_valid), .rsp_raw_result(rsp_raw_result),
      .rsp_float_out(rsp_float_out), .rsp_int_out(rsp_int_out),
      .rsp_less_than(rsp_less_than), .rsp_equal_to(rsp_equal_to),
      .rsp_greater_than(rsp_greater_than), .rsp_range_error(rsp_range_error)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         alu_sb.check_result({rsp_raw_result, rsp_float_out, rsp_int_out, rsp_less_than,
                              rsp_equal_to, rsp_greater_than, rsp_range_error});
      end
   end

   int gap_left = 0;

   task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                               input logic [31:0] b, input logic [31:0] f,
                               input logic [23:0] n);
      if (gap_left == 0 && $urandom_range(0, 5) == 0) begin
         gap_left = $urandom_range(1, 12);
      end
      while (gap_left > 0) begin
         start <= 1'b0;
         @(posedge clock);
         gap_left--;
      end
      start <= 1'b1;
      req_type <= op;
      req_op_a <= a;
      req_op_b <= b;
      req_float_in <= f;
      req_int_in <= n;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      alu_sb.note_request(op, a, b, f, n);
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      while (alu_sb.pending.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 3) - 1;
         3: return 32'($signed(12'($urandom)));
         4: return 32'($signed(20'($urandom)));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_single();
      logic [31:0] f;
      f = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         f[30:23] = 8'($urandom_range(100, 160));
      end
      return f;
   endfunction

   initial begin
      logic [3:0] op;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(fpa_pkg::OP_FROM_FLOAT, 0, 0, 32'h3fc0_0000, 0);
      send_request(fpa_pkg::OP_FROM_FLOAT, 0, 0, 32'hcb00_0000, 0);
      send_request(fpa_pkg::OP_FROM_FLOAT, 0, 0, 32'h4b00_0000, 0);
      send_request(fpa_pkg::OP_FROM_FLOAT, 0, 0, 32'h7fc0_0000, 0);
      send_request(fpa_pkg::OP_FROM_FLOAT, 0, 0, 32'h8000_0000, 0);
      send_request(fpa_pkg::OP_FROM_FLOAT, 0, 0, 32'h0000_0001, 0);
      send_request(fpa_pkg::OP_FROM_INT, 0, 0, 0, 24'h80_0000);
      send_request(fpa_pkg::OP_FROM_INT, 0, 0, 0, 24'h7f_ffff);
      send_request(fpa_pkg::OP_TO_FLOAT, 32'h8000_0000, 0, 0, 0);
      send_request(fpa_pkg::OP_TO_FLOAT, 0, 0, 0, 0);
      send_request(fpa_pkg::OP_TO_INT, 32'h7fff_ffff, 0, 0, 0);
      send_request(fpa_pkg::OP_TO_INT, 32'hffff_ff80, 0, 0, 0);
      send_request(fpa_pkg::OP_ADD, 32'h7fff_ffff, 1, 0, 0);
      send_request(fpa_pkg::OP_SUB, 32'h8000_0000, 1, 0, 0);
      send_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send_request(fpa_pkg::OP_DIV, 32'h0000_0100, 0, 0, 0);
      send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0, 0);
      send_request(fpa_pkg::OP_COMPARE, 5, 5, 0, 0);
      send_request(fpa_pkg::OP_INC, 32'h7fff_ffff, 0, 0, 0);
      send_request(fpa_pkg::OP_DEC, 32'h8000_0000, 0, 0, 0);
      send_request(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
      send_request(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
      send_request(4'd13, 1, 2, 3, 4);
      send_request(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 24'hff_ffff);
      drain_responses();
      for (int i = 0; i < 800; i++) begin
         op = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(13, 15))
                                           : 4'($urandom_range(0, 12));
         send_request(op, pick_word(), ($urandom_range(0, 15) == 0) ? 0 : pick_word(),
                      pick_single(), 24'($urandom));
         if (i == 400) begin
            drain_responses();
         end
      end
      drain_responses();
      repeat (FracWidth + 40) @(posedge clock);
      if (alu_sb.errors == 0 && alu_sb.pending.size() == 0) begin
         $display("[fixed_point_alu_with_float_convert_core] OK");
      end else begin
         $display("[fixed_point_alu_with_float_convert_core] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[fixed_point_alu_with_float_convert_core] ERROR");
      $finish;
   end

endmodule
